// File: rtl/pcm_sample_unpacker_defines.svh
// ----------------------------------------------------------------------------
// pcm_sample_unpacker_defines.svh
// Assertion macros shared by the sample unpacker RTL.
// ----------------------------------------------------------------------------
`ifndef PCM_SAMPLE_UNPACKER_DEFINES_SVH
`define PCM_SAMPLE_UNPACKER_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every edge outside reset
`define PCU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("pcm_sample_unpacker: assertion failed");
// expression must never be true outside reset
`define PCU_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("pcm_sample_unpacker: forbidden condition seen");
`else
`define PCU_ASSERT(lbl, clk, rst_n, prop)
`define PCU_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// File: rtl/pcu_pkg.sv
// ----------------------------------------------------------------------------
// pcu_pkg
// Constants, register codes and shared types of the PCM sample unpacker.
// ----------------------------------------------------------------------------
package pcu_pkg;

	// channel sizing
	localparam int MAX_CHANNELS = 8;
	localparam int CH_POS_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CH_CNT_W     = $clog2(MAX_CHANNELS + 1);
	localparam int CH_CMP_W     = ((CH_CNT_W > 4) ? CH_CNT_W : 4) + 1;

	// field widths
	localparam int SAMPLE_W     = 24;
	localparam int CHAN_IDX_W   = 3;
	localparam int BYTE_POS_W   = 2;
	localparam int PARTIAL_W    = 16;

	// configuration port
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 4;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHAN_SELECT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALL_CHANS   = 2'd3;

	// sample width codes
	localparam logic [1:0] MODE_U8  = 2'd0;
	localparam logic [1:0] MODE_S16 = 2'd1;
	localparam logic [1:0] MODE_S24 = 2'd2;

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [1:0] width_mode;
		logic [3:0] channel_count;
		logic [2:0] channel_select;
		logic       all_channels;
	} pcu_cfg_t;

	// one finished sample as raw bytes, ready for scaling
	typedef struct packed {
		logic [7:0]            last_byte;
		logic [PARTIAL_W-1:0]  partial;
		logic [1:0]            width_mode;
		logic [CHAN_IDX_W-1:0] channel_index;
		logic                  frame_end;
	} pcu_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} pcu_qstat_t;

endpackage

// File: rtl/pcu_front.sv
// ----------------------------------------------------------------------------
// pcu_front
// Accepts data bytes, tracks byte and channel position, queues finished
// samples of the channels that are to be emitted.
// ----------------------------------------------------------------------------
`include "pcm_sample_unpacker_defines.svh"

module pcu_front (
	input  logic               clk,
	input  logic               arst_n,
	input  pcu_pkg::pcu_cfg_t  cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               end_of_data,
	input  pcu_pkg::pcu_qstat_t qstat,
	output logic               push,
	output pcu_pkg::pcu_entry_t push_entry
);
	import pcu_pkg::*;

	logic [BYTE_POS_W-1:0] byte_pos_q;
	logic [CH_POS_W-1:0]   chan_pos_q;
	logic [PARTIAL_W-1:0]  partial_q;

	logic                  accept;
	logic [BYTE_POS_W-1:0] last_idx;
	logic [1:0]            norm_mode;
	logic                  complete;
	logic [CH_CMP_W-1:0]   cnt_ext;
	logic [CH_CMP_W-1:0]   nch;
	logic [CH_CMP_W-1:0]   pos_ext;
	logic                  fend;
	logic                  emit;
	logic [PARTIAL_W-1:0]  partial_next;

	// stall whenever the queue cannot take another sample
	assign in_stall = qstat.full;
	assign accept   = in_valid && !qstat.full;

	// width class; the unused code behaves as 24-bit
	always_comb begin
		case (cfg.width_mode)
			MODE_U8: begin
				norm_mode = MODE_U8;
				last_idx  = 2'd0;
			end
			MODE_S16: begin
				norm_mode = MODE_S16;
				last_idx  = 2'd1;
			end
			default: begin
				norm_mode = MODE_S24;
				last_idx  = 2'd2;
			end
		endcase
	end

	assign complete = byte_pos_q >= last_idx;

	// effective channel count: zero reads as one, saturate at the maximum
	always_comb begin
		cnt_ext = CH_CMP_W'(cfg.channel_count);
		if (cnt_ext == '0)
			nch = CH_CMP_W'(1);
		else if (cnt_ext > CH_CMP_W'(MAX_CHANNELS))
			nch = CH_CMP_W'(MAX_CHANNELS);
		else
			nch = cnt_ext;
	end

	assign pos_ext = CH_CMP_W'(chan_pos_q);
	assign fend    = (pos_ext + CH_CMP_W'(1)) >= nch;
	assign emit    = complete &&
		(cfg.all_channels || (pos_ext == CH_CMP_W'(cfg.channel_select)));

	// little-endian byte collection
	always_comb begin
		case (byte_pos_q)
			2'd0:    partial_next = {partial_q[15:8], data_byte};
			2'd1:    partial_next = {data_byte, partial_q[7:0]};
			default: partial_next = partial_q;
		endcase
	end

	// queue entry
	assign push                     = accept && emit;
	assign push_entry.last_byte     = data_byte;
	assign push_entry.partial       = partial_q;
	assign push_entry.width_mode    = norm_mode;
	assign push_entry.channel_index = pos_ext[CHAN_IDX_W-1:0];
	assign push_entry.frame_end     = fend;

	// position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			chan_pos_q <= '0;
			partial_q  <= '0;
		end else if (accept) begin
			if (end_of_data) begin
				byte_pos_q <= '0;
				chan_pos_q <= '0;
				partial_q  <= '0;
			end else if (complete) begin
				byte_pos_q <= '0;
				chan_pos_q <= fend ? '0 : chan_pos_q + CH_POS_W'(1);
				partial_q  <= '0;
			end else begin
				byte_pos_q <= byte_pos_q + BYTE_POS_W'(1);
				partial_q  <= partial_next;
			end
		end
	end

	`PCU_ASSERT(a_eod_clears, clk, arst_n, (accept && end_of_data) |=> (byte_pos_q == '0 && chan_pos_q == '0))
	`PCU_ASSERT_NEVER(a_byte_pos_range, clk, arst_n, byte_pos_q == 2'd3)

endmodule

// File: rtl/pcu_queue.sv
// ----------------------------------------------------------------------------
// pcu_queue
// Short flop queue that decouples byte intake from sample delivery.
// ----------------------------------------------------------------------------
`include "pcm_sample_unpacker_defines.svh"

module pcu_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pcu_pkg::pcu_entry_t push_entry,
	input  logic                pop,
	output pcu_pkg::pcu_entry_t head,
	output pcu_pkg::pcu_qstat_t qstat
);
	import pcu_pkg::*;

	pcu_entry_t         slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign qstat.full  = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign qstat.empty = count_q == '0;
	assign head        = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			if (push && !pop)
				count_q <= count_q + (FIFO_AW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (FIFO_AW+1)'(1);
		end
	end

	`PCU_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && qstat.full)
	`PCU_ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && qstat.empty)
	`PCU_ASSERT(a_count_range, clk, arst_n, count_q <= (FIFO_AW+1)'(FIFO_DEPTH))

endmodule

// File: rtl/pcu_back.sv
// ----------------------------------------------------------------------------
// pcu_back
// Scales queued samples to 24-bit two's complement and holds the result
// beat in the output register until it is taken.
// ----------------------------------------------------------------------------
module pcu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pcu_pkg::pcu_entry_t head,
	input  pcu_pkg::pcu_qstat_t qstat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [pcu_pkg::SAMPLE_W-1:0]   sample_value,
	output logic        [pcu_pkg::CHAN_IDX_W-1:0] channel_index,
	output logic                frame_end
);
	import pcu_pkg::*;

	logic                  out_valid_q;
	logic [SAMPLE_W-1:0]   value_q;
	logic [CHAN_IDX_W-1:0] chan_q;
	logic                  fend_q;
	logic [SAMPLE_W-1:0]   scaled;

	// 8-bit is offset binary; 16-bit sits in the upper two bytes
	always_comb begin
		case (head.width_mode)
			MODE_U8:  scaled = {head.last_byte ^ 8'h80, 16'h0000};
			MODE_S16: scaled = {head.last_byte, head.partial[7:0], 8'h00};
			default:  scaled = {head.last_byte, head.partial};
		endcase
	end

	// load when the register is free or its beat leaves this cycle
	assign pop = !qstat.empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!out_valid_q || !out_stall)
			out_valid_q <= !qstat.empty;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			value_q <= scaled;
			chan_q  <= head.channel_index;
			fend_q  <= head.frame_end;
		end
	end

	assign out_valid     = out_valid_q;
	assign sample_value  = signed'(value_q);
	assign channel_index = chan_q;
	assign frame_end     = fend_q;

endmodule

// File: rtl/pcm_sample_unpacker.sv
// ----------------------------------------------------------------------------
// pcm_sample_unpacker
// Little-endian interleaved PCM byte stream to 24-bit signed samples.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in        sink       in_valid/in_stall  data_byte, end_of_data
//  out       source     out_valid/out_stall sample_value, channel_index, frame_end
//  cfg       sink       cfg_we             cfg_index, cfg_wdata
//
//  One byte beat accepted per cycle while the queue is not full; after its
//  last byte a sample goes from the front decode into the queue, then the output register.
//  A four-entry queue lets intake run on while the output is stalled;
//  in_stall rises only when that queue is full.
//  Reset clears positions and the queue, and sets the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module pcm_sample_unpacker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [7:0]                             data_byte,
	input  logic                                   end_of_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [pcu_pkg::SAMPLE_W-1:0]    sample_value,
	output logic        [pcu_pkg::CHAN_IDX_W-1:0]  channel_index,
	output logic                                   frame_end,
	input  logic                                   cfg_we,
	input  logic [pcu_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [pcu_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
	import pcu_pkg::*;

	pcu_cfg_t   cfg_q;
	pcu_qstat_t qstat;
	pcu_entry_t push_entry;
	pcu_entry_t head;
	logic       push;
	logic       pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_mode     <= MODE_S16;
			cfg_q.channel_count  <= 4'd2;
			cfg_q.channel_select <= 3'd0;
			cfg_q.all_channels   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH_MODE:  cfg_q.width_mode     <= cfg_wdata[1:0];
				REG_CHAN_COUNT:  cfg_q.channel_count  <= cfg_wdata[3:0];
				REG_CHAN_SELECT: cfg_q.channel_select <= cfg_wdata[2:0];
				REG_ALL_CHANS:   cfg_q.all_channels   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	pcu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.end_of_data (end_of_data),
		.qstat       (qstat),
		.push        (push),
		.push_entry  (push_entry)
	);

	pcu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	pcu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.qstat         (qstat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_value  (sample_value),
		.channel_index (channel_index),
		.frame_end     (frame_end)
	);

endmodule
